>>> hw/rtl/frbf_pkg.sv
// ---------------------------------------------------------------------------
// frbf_pkg
// Types and constants shared by the fraction reduction block: payload
// structs, controller states and the command/status bundles.
// ---------------------------------------------------------------------------
package frbf_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int SHIFT_W     = $clog2(VALUE_WIDTH);
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] numerator;
    logic signed [VALUE_WIDTH-1:0] denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] reduced_numerator;
    logic signed [VALUE_WIDTH-1:0] reduced_denominator;
    logic                          left_unchanged;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV_N,
    ST_DIV_D,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_start;
    logic div_sel_d;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic zero_in;
    logic gcd_done;
    logic div_last;
  } status_t;

endpackage

>>> hw/rtl/fraction_reduce_by_factoring.sv
// ---------------------------------------------------------------------------
// fraction_reduce_by_factoring
// Reduces a signed fraction to lowest terms with unsigned magnitudes.
// ---------------------------------------------------------------------------
// Usage:
//   in_data carries numerator and denominator; an item is taken when
//   in_valid and in_ready are high together. out_data returns
//   |numerator|/gcd, |denominator|/gcd and left_unchanged = 0; if either
//   input is zero, both inputs come back as given with left_unchanged = 1.
// Timing:
//   one item at a time. load, then the binary gcd loop at 1 step per
//   cycle until an operand reaches zero, then one shared restoring
//   divider at one quotient bit per cycle for each quotient in turn,
//   then the output register; a zero input skips the loop and the
//   divider.
//   The gcd loop and the single divider set the time per item.
// Reset:
//   rst_n low on a clock edge empties the block; out_valid drops.
// Stall:
//   the result sits in an output register; while out_ready is low the
//   next item is still taken and worked on, then waits before hand-off.
// ---------------------------------------------------------------------------
module fraction_reduce_by_factoring (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  frbf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output frbf_pkg::out_item_t out_data
);

  frbf_pkg::cmd_t    cmd;
  frbf_pkg::status_t status;

  frbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  frbf_dpath u_dpath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

>>> hw/rtl/frbf_ctrl.sv
// ---------------------------------------------------------------------------
// frbf_ctrl
// Sequencer: load, binary gcd loop, two shared divisions, result hand-off.
// ---------------------------------------------------------------------------
module frbf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  frbf_pkg::status_t status,
  output frbf_pkg::cmd_t    cmd
);

  frbf_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frbf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      frbf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = frbf_pkg::ST_GCD;
        end
      end
      frbf_pkg::ST_GCD: begin
        if (status.zero_in) begin
          state_nxt = frbf_pkg::ST_HOLD;
        end else if (status.gcd_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = frbf_pkg::ST_DIV_N;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      frbf_pkg::ST_DIV_N: begin
        cmd.div_step = 1'b1;
        // last numerator bit: start the denominator division right away
        if (status.div_last) begin
          cmd.div_start = 1'b1;
          cmd.div_sel_d = 1'b1;
          state_nxt     = frbf_pkg::ST_DIV_D;
        end
      end
      frbf_pkg::ST_DIV_D: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = frbf_pkg::ST_HOLD;
        end
      end
      frbf_pkg::ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = frbf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = frbf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/frbf_dpath.sv
// ---------------------------------------------------------------------------
// frbf_dpath
// Datapath: magnitudes, binary gcd registers, one restoring divider shared
// by both quotients, and the output register.
// ---------------------------------------------------------------------------
module frbf_dpath (
  input  logic                clk,
  input  frbf_pkg::in_item_t  in_data,
  input  frbf_pkg::cmd_t      cmd,
  output frbf_pkg::status_t   status,
  output frbf_pkg::out_item_t out_data
);

  localparam int W = frbf_pkg::VALUE_WIDTH;

  logic [W-1:0]                 n_raw_r, d_raw_r;
  logic [W-1:0]                 mn_r, md_r;
  logic [W-1:0]                 a_r, b_r;
  logic [frbf_pkg::SHIFT_W-1:0] k_r;
  logic                         zero_r;
  logic [W-1:0]                 g_r;
  logic [W-1:0]                 rem_r, quo_r;
  logic [frbf_pkg::CNT_W-1:0]   cnt_r;
  logic                         sel_d_r;
  logic [W-1:0]                 res_n_r, res_d_r;
  frbf_pkg::out_item_t          out_r;

  logic [W-1:0] in_n, in_d, mag_n, mag_d;
  logic [W:0]   ab_diff;
  logic [W-1:0] ba_diff;
  logic [W:0]   rem_sh, rem_diff;
  logic [W-1:0] rem_nxt, quo_nxt;

  assign in_n  = in_data.numerator;
  assign in_d  = in_data.denominator;
  assign mag_n = in_n[W-1] ? (~in_n + 1'b1) : in_n;
  assign mag_d = in_d[W-1] ? (~in_d + 1'b1) : in_d;

  assign ab_diff = {1'b0, a_r} - {1'b0, b_r};
  assign ba_diff = b_r - a_r;

  // one quotient bit per cycle
  assign rem_sh   = {rem_r, quo_r[W-1]};
  assign rem_diff = rem_sh - {1'b0, g_r};
  assign rem_nxt  = rem_diff[W] ? rem_sh[W-1:0] : rem_diff[W-1:0];
  assign quo_nxt  = {quo_r[W-2:0], ~rem_diff[W]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_raw_r <= in_n;
      d_raw_r <= in_d;
      mn_r    <= mag_n;
      md_r    <= mag_d;
      a_r     <= mag_n;
      b_r     <= mag_d;
      k_r     <= '0;
      zero_r  <= (in_n == '0) || (in_d == '0);
    end else if (cmd.gcd_step) begin
      priority if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (!ab_diff[W]) begin
        a_r <= ab_diff[W-1:0] >> 1;
      end else begin
        b_r <= ba_diff >> 1;
      end
    end

    if (cmd.div_step && (cnt_r == frbf_pkg::CNT_W'(W - 1))) begin
      if (sel_d_r) begin
        res_d_r <= quo_nxt;
      end else begin
        res_n_r <= quo_nxt;
      end
    end

    if (cmd.div_start) begin
      g_r     <= (a_r | b_r) << k_r;
      rem_r   <= '0;
      quo_r   <= cmd.div_sel_d ? md_r : mn_r;
      cnt_r   <= '0;
      sel_d_r <= cmd.div_sel_d;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + 1'b1;
    end

    if (cmd.out_load) begin
      out_r.reduced_numerator   <= zero_r ? n_raw_r : res_n_r;
      out_r.reduced_denominator <= zero_r ? d_raw_r : res_d_r;
      out_r.left_unchanged      <= zero_r;
    end
  end

  assign status.zero_in  = zero_r;
  assign status.gcd_done = (a_r == '0) || (b_r == '0);
  assign status.div_last = (cnt_r == frbf_pkg::CNT_W'(W - 1));
  assign out_data        = out_r;

endmodule

>>> hw/rtl/frbf_checker.sv
// ---------------------------------------------------------------------------
// frbf_checker
// Port-level checks for the fraction reduction block.
// ---------------------------------------------------------------------------
module frbf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input frbf_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input frbf_pkg::out_item_t out_data
);

  // a waiting input item holds still
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while waiting");

  // a held result does not change or vanish
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // pass-through only happens with a zero field
  a_unchanged_has_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.left_unchanged |->
      (out_data.reduced_numerator == '0) || (out_data.reduced_denominator == '0))
    else $error("left_unchanged without a zero value");

  // reduced results are never zero
  a_reduced_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.left_unchanged |->
      (out_data.reduced_numerator != '0) && (out_data.reduced_denominator != '0))
    else $error("reduced result is zero");

endmodule

bind fraction_reduce_by_factoring frbf_checker u_frbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
